[hdl/mdg_pkg.sv]
// Package for the division magic number generator: field widths, the word
// carried through the divider pipeline and a bit-length helper.
// No dependencies.
package mdg_pkg;

    localparam int DATA_W  = 32;
    localparam int SHIFT_W = 6;
    localparam int TDATA_W = 40;

    typedef struct packed {
        logic               valid;
        logic               zero;
        logic [DATA_W-1:0]  d;
        logic [SHIFT_W-1:0] l;
        logic [DATA_W-1:0]  rem;
        logic [DATA_W-1:0]  quot;
        logic [DATA_W-1:0]  rem_half;
    } div_word_t;

    function automatic logic [SHIFT_W-1:0] bit_length(input logic [DATA_W-1:0] x);
        logic [SHIFT_W-1:0] n;
        n = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (x[i])
            begin
                n = SHIFT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[hdl/mdg_div_step.sv]
// One restoring division step of the magic number pipeline, registered.
// Depends on mdg_pkg for div_word_t.
module mdg_div_step
    import mdg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  div_word_t in_word,
    output div_word_t out_word
);

    div_word_t            word_reg;
    div_word_t            word_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W+1:0]    diff;
    logic                 take;

    always_comb
    begin
        shifted = {in_word.rem, 1'b0};
        diff    = {1'b0, shifted} - {2'b00, in_word.d};
        take    = !diff[DATA_W+1];

        word_next          = in_word;
        word_next.rem      = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        word_next.quot     = {in_word.quot[DATA_W-2:0], take};
        // keep the partial remainder entering this step
        word_next.rem_half = in_word.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_word = word_reg;

endmodule

[hdl/division_magic_number_generator_top.sv]
// Top level of the unsigned 32-bit division magic number generator.
// Depends on mdg_pkg and mdg_div_step.
//
//  channel | dir | handshake           | contents
//  s_*     | in  | s_tvalid / s_tready | divisor
//  m_*     | out | m_tvalid / m_tready | multiplier, pre_shift, post_shift; invalid
//  cfg_*   | in  | cfg_valid/cfg_ready | plain_mode
//
// One divisor is accepted per cycle while the skid register is empty; each result
// passes through the 32 restoring division steps, one per pipeline stage, plus the
// bit-length stage and the result stage.
// Reset clears all valid bits and plain_mode; no clearing pass is needed.
// An output stall fills a skid register; only then does the pipeline freeze.
module division_magic_number_generator_top
    import mdg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // [31:0] divisor
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] multiplier, [32] pre_shift,
                                          // [38:33] post_shift, [39] pad, always 0
    output logic               m_tuser,   // [0] invalid
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data   // [0] plain_mode
);

    localparam int STEPS = DATA_W;
    localparam int RES_W = DATA_W + 1 + SHIFT_W + 1;

    logic                 plain_mode_reg;
    logic                 en;
    div_word_t            front_reg;
    div_word_t            front_next;
    logic [DATA_W-1:0]    d_less;
    logic [DATA_W-1:0]    smear;
    div_word_t            chain [0:STEPS];

    logic                 out_valid_reg;
    logic [RES_W-1:0]     out_reg;
    logic                 skid_valid_reg;
    logic [RES_W-1:0]     skid_reg;
    logic [RES_W-1:0]     res_next;
    logic                 push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            plain_mode_reg <= cfg_data;
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb
    begin
        d_less = s_tdata - DATA_W'(1);
        smear[DATA_W-1] = d_less[DATA_W-1];
        for (int i = DATA_W - 2; i >= 0; i--)
        begin
            smear[i] = smear[i+1] | d_less[i];
        end

        front_next          = '0;
        front_next.valid    = s_tvalid;
        front_next.zero     = (s_tdata == '0);
        front_next.d        = s_tdata;
        front_next.l        = bit_length(d_less);
        front_next.rem      = ~d_less & smear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
        end
    end

    assign chain[0] = front_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        mdg_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_word  (chain[k]),
            .out_word (chain[k+1])
        );
    end

    div_word_t           last;
    logic [DATA_W-1:0]   magic;
    logic [DATA_W-1:0]   half;
    logic [DATA_W-1:0]   q_plus;
    logic                round_up;
    logic [DATA_W-1:0]   m_val;
    logic                s1_val;
    logic [SHIFT_W-1:0]  s2_val;

    always_comb
    begin
        last     = chain[STEPS];
        magic    = last.quot;
        half     = (last.l == '0) ? '0 : (DATA_W'(1) << (last.l - SHIFT_W'(1)));
        q_plus   = {1'b1, magic[DATA_W-1:1]} + DATA_W'(1);
        round_up = (last.rem_half > (last.d - half));

        m_val  = magic + DATA_W'(1);
        s1_val = (last.l != '0);
        s2_val = (last.l == '0) ? '0 : last.l - SHIFT_W'(1);

        if (!plain_mode_reg)
        begin
            if (magic == '0)
            begin
                m_val  = '0;
                s1_val = 1'b0;
                s2_val = last.l;
            end
            else if (round_up)
            begin
                m_val  = q_plus;
                s1_val = 1'b0;
            end
        end

        if (last.zero)
        begin
            res_next = {1'b1, {(RES_W-1){1'b0}}};
        end
        else
        begin
            res_next = {1'b0, s2_val, s1_val, m_val};
        end
    end

    assign push = en && last.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        end
        else if (push)
        begin
            skid_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg[RES_W-2:0]};
    assign m_tuser  = out_reg[RES_W-1];

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("invalid result carries nonzero fields");

    a_post_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38:33] <= 6'd32))
        else $error("post_shift out of range");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && last.valid) |=> last.valid)
        else $error("final pipeline word lost during stall");

endmodule

[dv/magic_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the division magic number generator: predicts the multiplier and
// shift counts of every accepted divisor and compares them with the output words.
// Depends on mdg_pkg.
module magic_result_checker
    import mdg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [DATA_W-1:0]  multiplier;
        logic               pre_shift;
        logic [SHIFT_W-1:0] post_shift;
        logic               invalid;
    } magic_t;

    localparam logic [63:0] LOW32 = 64'h0000_0000_FFFF_FFFF;

    magic_t expected_magic[$];
    logic   plain_mode;
    int     fail_count;

    assign errors  = fail_count;

    function automatic magic_t predict_magic(input logic [DATA_W-1:0] d, input logic plain);
        magic_t            res;
        logic [DATA_W-1:0] d_less;
        logic [63:0]       dw;
        logic [63:0]       p2;
        logic [63:0]       magic;
        logic [63:0]       q;
        logic [63:0]       r;
        int                l;
        res = '0;
        if (d == '0)
        begin
            res.invalid = 1'b1;
            return res;
        end
        d_less = d - 32'd1;
        l = 0;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (d_less[i])
            begin
                l = i + 1;
            end
        end
        dw    = {32'b0, d};
        p2    = 64'd1 << l;
        magic = (((p2 - dw) << 32) / dw) & LOW32;
        res.multiplier = magic[31:0] + 32'd1;
        res.pre_shift  = (l > 0);
        res.post_shift = (l == 0) ? '0 : SHIFT_W'(l - 1);
        if (!plain)
        begin
            if (magic == 64'd0)
            begin
                res.multiplier = '0;
                if (d == 32'd1)
                begin
                    res.pre_shift  = 1'b0;
                    res.post_shift = '0;
                end
                else
                begin
                    res.pre_shift  = res.pre_shift - 1'b1;
                    res.post_shift = res.post_shift + SHIFT_W'(1);
                end
            end
            else
            begin
                q = (magic + 64'h1_0000_0000) >> 1;
                r = ((p2 << 31) - ((q * dw) & LOW32)) & LOW32;
                if (r > dw - (p2 >> 1))
                begin
                    res.multiplier = q[31:0] + 32'd1;
                    res.pre_shift  = res.pre_shift - 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Outputs and inputs change only at the rising edge, so the levels seen at the
    // falling edge are the ones the next rising edge accepts.
    always @(negedge clk)
    begin
        magic_t got;
        magic_t want;
        if (!rst_n)
        begin
            plain_mode = 1'b0;
            expected_magic.delete();
            fail_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_magic.push_back(predict_magic(s_tdata, plain_mode));
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[31:0], m_tdata[32], m_tdata[38:33], m_tuser};
                if (expected_magic.size() == 0)
                begin
                    $display("%0t: unexpected word: multiplier %h pre %0d post %0d invalid %0d",
                             $time, got.multiplier, got.pre_shift, got.post_shift,
                             got.invalid);
                    fail_count++;
                end
                else
                begin
                    want = expected_magic.pop_front();
                    if (got !== want || m_tdata[39] !== 1'b0)
                    begin
                        $display("%0t: expected multiplier %h pre %0d post %0d invalid %0d",
                                 $time, want.multiplier, want.pre_shift, want.post_shift,
                                 want.invalid);
                        $display("%0t: actual   multiplier %h pre %0d post %0d invalid %0d pad %b",
                                 $time, got.multiplier, got.pre_shift, got.post_shift,
                                 got.invalid, m_tdata[39]);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                plain_mode = cfg_data;
            end
        end
        pending = expected_magic.size();
    end

endmodule

[dv/division_magic_number_generator_top_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for division_magic_number_generator_top: corner and random
// divisors under both modes, with bursty gaps and output stalls.
// Depends on mdg_pkg, the block under test and magic_result_checker.
module division_magic_number_generator_top_test
    import mdg_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 255;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    int   errors;
    int   pending;
    logic idle_on;
    logic mode;
    int   plain_sent;
    int   refined_sent;
    int   mode_writes;
    int   stall_left;
    int   quiet_cycles;

    logic [DATA_W-1:0] corner_divisors[13] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd641,
        32'h4000_0000, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    division_magic_number_generator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    magic_result_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold ready low in bursts of random length while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("division_magic_number_generator_top: mismatch");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_divisor();
        case ($urandom_range(0, 9))
            0:       return 32'd1 << $urandom_range(0, 31);
            1:       return (32'd1 << $urandom_range(1, 31)) + 32'd1;
            2:       return (32'd1 << $urandom_range(1, 31)) - 32'd1;
            3:       return $urandom_range(0, 64);
            4:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_divisor(input logic [DATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(negedge clk);
        while (!s_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        if (mode)
        begin
            plain_sent++;
        end
        else
        begin
            refined_sent++;
        end
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic write_mode(input logic value);
        s_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        mode = value;
        mode_writes++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        idle_on      = 1'b0;
        mode         = 1'b0;
        plain_sent   = 0;
        refined_sent = 0;
        mode_writes  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_divisors[i])
        begin
            send_divisor(corner_divisors[i]);
        end
        write_mode(1'b1);
        foreach (corner_divisors[i])
        begin
            send_divisor(corner_divisors[i]);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_mode(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Re-choose idling every 50 words; drop it in the last phase.
                if (n % 50 == 0)
                begin
                    idle_on <= (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                send_divisor(random_divisor());
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Sent %0d divisors in plain mode and %0d in refined mode, %0d mode writes,",
                 plain_sent, refined_sent, mode_writes);
        $display("with corner divisors, powers of two and their neighbors, and random values.");
        if (errors == 0 && pending == 0)
        begin
            $display("division_magic_number_generator_top: match");
        end
        else
        begin
            $display("division_magic_number_generator_top: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/mdg_pkg.sv
hdl/mdg_div_step.sv
hdl/division_magic_number_generator_top.sv
dv/magic_result_checker.sv
dv/division_magic_number_generator_top_test.sv
